### src/pxhex_pkg.sv
// Package for the pixel-to-hexagon locator: widths, fixed-point constants,
// register indexes and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package pxhex_pkg;

	// Coordinate format of points and origin: signed, FRAC_BITS fraction bits.
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS = 4;
	localparam int OUT_BITS = 14;
	localparam int RADIUS_W = 10;

	// Configuration port.
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 2;
	localparam int APB_AW = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 2'd2;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd32;

	// sqrt3 in Q16. Every numerator and the denominator share a factor of 8,
	// which is dropped to keep the datapath narrower.
	localparam int SQRT3_Q16 = 113512;
	localparam int NUM_SHIFT = 3;
	localparam int SQRT3_C = SQRT3_Q16 >> NUM_SHIFT;
	localparam int SQRT3_W = 15;
	localparam int DY_SH = 16 - NUM_SHIFT;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int NUM_W = COORD_BITS + 16;
	localparam int MAG_W = COORD_BITS + 15;
	localparam int DEN_SH = FRAC_BITS + 16 - NUM_SHIFT;
	localparam int R3_W = RADIUS_W + 2;
	localparam int DEN_W = R3_W + DEN_SH;

	// Rounded quotient magnitude always stays below 2^QBITS.
	localparam int QBITS = (COORD_BITS > FRAC_BITS) ? (COORD_BITS - FRAC_BITS + 1) : 1;
	localparam int XW = ((MAG_W > DEN_W) ? MAG_W : DEN_W) + 2;
	localparam int YQ_W = DEN_W + 1 + QBITS;
	localparam int DIV_W = (XW > YQ_W) ? XW : YQ_W;
	localparam int ERR_W = DEN_W + 1;
	localparam int RES_W = QBITS + 3;
	localparam int SAT_W = (RES_W > OUT_BITS) ? RES_W : OUT_BITS;

	// Cube components in lane order.
	localparam int LANES = 3;
	localparam int LANE_Q = 0;
	localparam int LANE_R = 1;
	localparam int LANE_S = 2;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
	} cfg_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QBITS-1:0] quo;
		logic neg;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0] lane;
		logic [DEN_W-1:0] den;
	} div_t;

endpackage

### src/pxhex_if.sv
// Handshake channels of the pixel-to-hexagon locator: query points in,
// hexagon offset coordinates out. Depends on pxhex_pkg for field widths.
`timescale 1ns / 1ps

interface pxhex_point_if;
	import pxhex_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface pxhex_hex_if;
	import pxhex_pkg::*;
	logic valid;
	logic ready;
	logic signed [OUT_BITS-1:0] hex_col;
	logic signed [OUT_BITS-1:0] hex_row;

	modport source (output valid, output hex_col, output hex_row, input ready);
	modport sink (input valid, input hex_col, input hex_row, output ready);
endinterface

### src/pxhex_cfg.sv
// APB-style register file: hex radius and grid origin.
// Depends on pxhex_pkg for register indexes, widths and cfg_t.
`timescale 1ns / 1ps

module pxhex_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pxhex_pkg::APB_AW-1:0]  paddr,
	input  logic [pxhex_pkg::APB_DW-1:0]  pwdata,
	output logic [pxhex_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output pxhex_pkg::cfg_t               cfg
);
	import pxhex_pkg::*;

	logic [RADIUS_W-1:0] radius_q;
	logic [COORD_BITS-1:0] origin_x_q;
	logic [COORD_BITS-1:0] origin_y_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = paddr[APB_AW-1:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_RADIUS: begin
					radius_q <= pwdata[RADIUS_W-1:0];
				end
				REG_ORIGIN_X: begin
					origin_x_q <= pwdata[COORD_BITS-1:0];
				end
				REG_ORIGIN_Y: begin
					origin_y_q <= pwdata[COORD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RADIUS:   prdata = {{(APB_DW-RADIUS_W){1'b0}}, radius_q};
			REG_ORIGIN_X: prdata = {{(APB_DW-COORD_BITS){1'b0}}, origin_x_q};
			REG_ORIGIN_Y: prdata = {{(APB_DW-COORD_BITS){1'b0}}, origin_y_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.radius = radius_q;
	assign cfg.origin_x = origin_x_q;
	assign cfg.origin_y = origin_y_q;

endmodule

### src/pxhex_front.sv
// Front end of the locator: origin subtraction, the sqrt3 multiply, the three
// cube numerators and the rounding dividends. Four pipeline stages.
// Depends on pxhex_pkg.
`timescale 1ns / 1ps

module pxhex_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pxhex_pkg::cfg_t                     cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pxhex_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [pxhex_pkg::COORD_BITS-1:0] point_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pxhex_pkg::div_t                     out_data
);
	import pxhex_pkg::*;

	localparam logic signed [SQRT3_W-1:0] SQRT3_K = SQRT3_W'(SQRT3_C);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [DEN_W-1:0] den_s1, den_s2, den_s3;
	logic signed [NUM_W-1:0] prod_s2;
	logic signed [DIFF_W-1:0] dy_s2;
	logic signed [NUM_W-1:0] m_s3 [LANES];
	div_t data_s4;

	logic [RADIUS_W-1:0] rad_eff;
	logic [R3_W-1:0] rad3;
	logic signed [NUM_W-1:0] dy_ext;
	div_t lanes_nxt;

	// A stage moves when it is empty or the next one moves.
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Zero radius counts as one; the denominator is 3*R scaled.
	assign rad_eff = (cfg.radius == '0) ? RADIUS_W'(1) : cfg.radius;
	assign rad3 = R3_W'(rad_eff) + R3_W'({rad_eff, 1'b0});

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1 <= {point_x[COORD_BITS-1], point_x}
				- {cfg.origin_x[COORD_BITS-1], cfg.origin_x};
			dy_s1 <= {point_y[COORD_BITS-1], point_y}
				- {cfg.origin_y[COORD_BITS-1], cfg.origin_y};
			den_s1 <= {rad3, {DEN_SH{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= dx_s1 * SQRT3_K;
			dy_s2 <= dy_s1;
			den_s2 <= den_s1;
		end
	end

	assign dy_ext = NUM_W'(dy_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			m_s3[LANE_Q] <= prod_s2 - (dy_ext <<< DY_SH);
			m_s3[LANE_R] <= dy_ext <<< (DY_SH + 1);
			m_s3[LANE_S] <= -(prod_s2 + (dy_ext <<< DY_SH));
			den_s3 <= den_s2;
		end
	end

	// Dividend 2|N| + D, so that the quotient by 2D rounds half away from zero.
	always_comb begin
		logic signed [NUM_W-1:0] absval;
		absval = '0;
		lanes_nxt.den = den_s3;
		for (int l = 0; l < LANES; l++) begin
			absval = m_s3[l][NUM_W-1] ? -m_s3[l] : m_s3[l];
			lanes_nxt.lane[l].neg = m_s3[l][NUM_W-1];
			lanes_nxt.lane[l].quo = '0;
			lanes_nxt.lane[l].rem = DIV_W'({absval[MAG_W-1:0], 1'b0}) + DIV_W'(den_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) data_s4 <= lanes_nxt;
	end

	assign out_valid = v_s4;
	assign out_data = data_s4;

endmodule

### src/pxhex_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes in
// step (q, r, s) sharing one divisor. Depends on pxhex_pkg.
`timescale 1ns / 1ps

module pxhex_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pxhex_pkg::div_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output pxhex_pkg::div_t out_data
);
	import pxhex_pkg::*;

	logic stage_v_s [QBITS];
	div_t stage_d_s [QBITS];
	logic rdy [QBITS+1];

	assign rdy[QBITS] = out_ready;

	for (genvar j = 0; j < QBITS; j++) begin : g_stage
		localparam int BIT = QBITS - 1 - j;
		logic prev_v;
		div_t prev_d;
		div_t nxt;
		logic [DIV_W-1:0] ysh;

		if (j == 0) begin : g_head
			assign prev_v = in_valid;
			assign prev_d = in_data;
		end else begin : g_body
			assign prev_v = stage_v_s[j-1];
			assign prev_d = stage_d_s[j-1];
		end

		assign rdy[j] = !stage_v_s[j] || rdy[j+1];
		assign ysh = DIV_W'({prev_d.den, 1'b0}) << BIT;

		always_comb begin
			nxt = prev_d;
			for (int l = 0; l < LANES; l++) begin
				if (prev_d.lane[l].rem >= ysh) begin
					nxt.lane[l].rem = prev_d.lane[l].rem - ysh;
					nxt.lane[l].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_v_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				stage_v_s[j] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j]) stage_d_s[j] <= nxt;
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = stage_v_s[QBITS-1];
	assign out_data = stage_d_s[QBITS-1];

endmodule

### src/pxhex_round.sv
// Back end of the locator: rounding errors, rebuild of the worst-rounded
// cube component, odd-r column and saturation. Three stages, the last one
// is the output register. Depends on pxhex_pkg.
`timescale 1ns / 1ps

module pxhex_round (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  pxhex_pkg::div_t                       in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pxhex_pkg::OUT_BITS-1:0] hex_col,
	output logic signed [pxhex_pkg::OUT_BITS-1:0] hex_row
);
	import pxhex_pkg::*;

	localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((1 <<< (OUT_BITS - 1)) - 1);
	localparam logic signed [SAT_W-1:0] OUT_MIN = -OUT_MAX - SAT_W'(1);

	function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [RES_W-1:0] v);
		logic signed [SAT_W-1:0] w;
		w = SAT_W'(v);
		if (w > OUT_MAX) w = OUT_MAX;
		else if (w < OUT_MIN) w = OUT_MIN;
		return w[OUT_BITS-1:0];
	endfunction

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [ERR_W-1:0] err_s1 [LANES];
	logic signed [RES_W-1:0] k_s1 [LANES];
	logic signed [RES_W-1:0] q_s2, r_s2;
	logic signed [OUT_BITS-1:0] col_s3, row_s3;

	logic [ERR_W-1:0] err_nxt [LANES];
	logic signed [RES_W-1:0] k_nxt [LANES];
	logic signed [RES_W-1:0] q_nxt, r_nxt, col_nxt;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// The final remainder minus D is twice the signed rounding error.
	always_comb begin
		logic [ERR_W-1:0] rem;
		logic [ERR_W-1:0] den;
		logic signed [RES_W-1:0] mag;
		rem = '0;
		den = ERR_W'(in_data.den);
		mag = '0;
		for (int l = 0; l < LANES; l++) begin
			rem = in_data.lane[l].rem[ERR_W-1:0];
			err_nxt[l] = (rem >= den) ? (rem - den) : (den - rem);
			mag = RES_W'(in_data.lane[l].quo);
			k_nxt[l] = in_data.lane[l].neg ? -mag : mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			err_s1 <= err_nxt;
			k_s1 <= k_nxt;
		end
	end

	// Strict compares: on a tie the later component is the one rebuilt.
	always_comb begin
		q_nxt = k_s1[LANE_Q];
		r_nxt = k_s1[LANE_R];
		if (err_s1[LANE_Q] > err_s1[LANE_R] && err_s1[LANE_Q] > err_s1[LANE_S]) begin
			q_nxt = -k_s1[LANE_R] - k_s1[LANE_S];
		end else if (err_s1[LANE_R] > err_s1[LANE_S]) begin
			r_nxt = -k_s1[LANE_Q] - k_s1[LANE_S];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			q_s2 <= q_nxt;
			r_s2 <= r_nxt;
		end
	end

	// Odd-r column: q plus floor(r/2).
	assign col_nxt = q_s2 + (r_s2 >>> 1);

	always_ff @(posedge clk) begin
		if (en3) begin
			col_s3 <= sat_out(col_nxt);
			row_s3 <= sat_out(r_s2);
		end
	end

	assign out_valid = v_s3;
	assign hex_col = col_s3;
	assign hex_row = row_s3;

endmodule

### src/pixel_to_hex_offset_coords.sv
// Top level of the pixel-to-hexagon locator for a pointy-top, odd-r grid.
// Depends on pxhex_pkg, pxhex_if and the cfg, front, div and round modules.
`timescale 1ns / 1ps

// Usage
// The pixel channel carries a query point (point_x, point_y, signed fixed
// point with four fraction bits). The tile channel returns the odd-r offset
// column and row of the hexagon that contains it. A transfer happens on any
// rising edge where valid and ready are both high; one result per point, in
// order.
// The APB port holds the radius (whole pixels, 0 acts as 1) and the grid
// origin; write them only while no point is in flight.
// Throughput is one point per cycle while tile.ready stays high. A point
// passes four front stages, one divider stage per quotient bit of the
// rounding division by 3*R, and three back stages ending in the output
// register.
// Every stage has its own valid bit and moves when it is empty or its
// successor moves, so a stalled receiver fills the bubbles first and only
// then drops pixel.ready. Nothing is lost or repeated across a stall.
// Reset clears all valid bits and loads the register defaults: radius 32,
// origin zero.

module pixel_to_hex_offset_coords (
	input  logic                          clk,
	input  logic                          arst_n,
	pxhex_point_if.sink                   pixel,
	pxhex_hex_if.source                   tile,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pxhex_pkg::APB_AW-1:0]  paddr,
	input  logic [pxhex_pkg::APB_DW-1:0]  pwdata,
	output logic [pxhex_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import pxhex_pkg::*;

	cfg_t cfg;

	// Front end to divider.
	logic front_valid, front_ready;
	div_t front_data;

	// Divider to back end.
	logic div_valid, div_ready;
	div_t div_data;

	pxhex_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Origin subtraction, numerators of q, r and s, and the dividends.
	pxhex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.point_x   (pixel.point_x),
		.point_y   (pixel.point_y),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	// Exact rounded division of each numerator by 3*R.
	pxhex_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	// Cube fix-up, odd-r conversion and saturation to the output width.
	pxhex_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (tile.valid),
		.out_ready (tile.ready),
		.hex_col   (tile.hex_col),
		.hex_row   (tile.hex_row)
	);

endmodule

### tb/hex_tile_checker.sv
// Checker for the pixel-to-hexagon locator: watches the point, tile and APB
// channels, predicts each tile and compares it with what the block returns.
// Depends on pxhex_pkg and the channel interfaces in pxhex_if.
`timescale 1ns / 1ps

module hex_tile_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	pxhex_point_if                       pixel,
	pxhex_hex_if                         tile,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [pxhex_pkg::APB_AW-1:0] paddr,
	input  logic [pxhex_pkg::APB_DW-1:0] pwdata,
	output int                           mismatches,
	output int                           tiles_owed,
	output int                           points_seen,
	output int                           tiles_checked
);
	import pxhex_pkg::*;

	// sqrt3 scaled by 2^16 and rounded to nearest.
	localparam longint SQRT3_FIX = 113512;
	localparam int DEN_SHIFT = FRAC_BITS + 16;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] col;
		logic signed [OUT_BITS-1:0] row;
	} hex_loc_t;

	logic [RADIUS_W-1:0] grid_radius;
	logic signed [COORD_BITS-1:0] grid_ox;
	logic signed [COORD_BITS-1:0] grid_oy;
	hex_loc_t owed_tiles[$];
	int errs;
	int seen;
	int checked;

	// Nearest integer to num/den with halves away from zero; den is positive.
	function automatic longint round_away(input longint num, input longint den,
			output longint err);
		longint mag;
		longint k;
		mag = (num < 0) ? -num : num;
		k = (2 * mag + den) / (2 * den);
		if (num < 0)
			k = -k;
		err = num - k * den;
		if (err < 0)
			err = -err;
		return k;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] clamp_out(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi[OUT_BITS-1:0];
		if (v < lo)
			return lo[OUT_BITS-1:0];
		return v[OUT_BITS-1:0];
	endfunction

	// Cube coordinates are kept exact as numerators over 3*R*2^(FRAC_BITS+16).
	function automatic hex_loc_t locate_hex(input logic signed [COORD_BITS-1:0] px,
			input logic signed [COORD_BITS-1:0] py);
		longint rad;
		longint dx;
		longint dy;
		longint den;
		longint nq;
		longint nr;
		longint ns;
		longint cq;
		longint cr;
		longint cs;
		longint eq;
		longint er;
		longint es;
		hex_loc_t loc;
		rad = (grid_radius == '0) ? 1 : longint'(grid_radius);
		dx = longint'(px) - longint'(grid_ox);
		dy = longint'(py) - longint'(grid_oy);
		den = 3 * rad * (longint'(1) <<< DEN_SHIFT);
		nq = SQRT3_FIX * dx - dy * 65536;
		nr = dy * 131072;
		ns = -nq - nr;
		cq = round_away(nq, den, eq);
		cr = round_away(nr, den, er);
		cs = round_away(ns, den, es);
		if (eq > er && eq > es)
			cq = -cr - cs;
		else if (er > es)
			cr = -cq - cs;
		// Arithmetic shift gives floor(r/2) for either sign.
		loc.col = clamp_out(cq + (cr >>> 1));
		loc.row = clamp_out(cr);
		return loc;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hex_loc_t want;
		if (!arst_n) begin
			grid_radius = 10'd32;
			grid_ox = '0;
			grid_oy = '0;
			owed_tiles.delete();
			errs = 0;
			seen = 0;
			checked = 0;
		end else begin
			if (tile.valid && tile.ready) begin
				if (owed_tiles.size() == 0) begin
					report_mismatch($sformatf("tile (%0d, %0d) with no point outstanding",
						tile.hex_col, tile.hex_row));
				end else begin
					want = owed_tiles.pop_front();
					if (tile.hex_col !== want.col)
						report_mismatch($sformatf("tile %0d hex_col %0d, expected %0d",
							checked, tile.hex_col, want.col));
					if (tile.hex_row !== want.row)
						report_mismatch($sformatf("tile %0d hex_row %0d, expected %0d",
							checked, tile.hex_row, want.row));
				end
				checked++;
			end
			if (pixel.valid && pixel.ready) begin
				owed_tiles.push_back(locate_hex(pixel.point_x, pixel.point_y));
				seen++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_RADIUS: grid_radius = pwdata[RADIUS_W-1:0];
					REG_ORIGIN_X: grid_ox = pwdata[COORD_BITS-1:0];
					REG_ORIGIN_Y: grid_oy = pwdata[COORD_BITS-1:0];
					default: ;
				endcase
			end
		end
		mismatches <= errs;
		tiles_owed <= owed_tiles.size();
		points_seen <= seen;
		tiles_checked <= checked;
	end

endmodule

### tb/tb.sv
// Top of the pixel-to-hexagon locator testbench: clock, reset, point and
// APB stimulus, tile receiver with stalls, watchdog and the final verdict.
// Depends on pxhex_pkg, pxhex_if, the block and hex_tile_checker.
`timescale 1ns / 1ps

module tb;
	import pxhex_pkg::*;

	// The final settle time and the receiver hold-off are sized well beyond
	// the block's latency at the default widths.
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 90;
	localparam int STALL_LIMIT = 2000;
	localparam int POINTS_PER_PHASE = 206;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pxhex_point_if pixel ();
	pxhex_hex_if tile ();

	int mismatches;
	int tiles_owed;
	int points_seen;
	int tiles_checked;

	// Shared between the point sender and the tile receiver.
	bit idling;
	bit hold_request;
	bit rx_holding;

	// Grid setting currently loaded, used to aim points at interesting spots.
	int cur_radius;
	int cur_ox;
	int cur_oy;
	int settings_count;
	int quiet_cycles;

	pixel_to_hex_offset_coords uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.tile    (tile),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hex_tile_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel         (pixel),
		.tile          (tile),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.tiles_owed    (tiles_owed),
		.points_seen   (points_seen),
		.tiles_checked (tiles_checked)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one point and returns right after the edge that transfers it.
	// Valid is left high, so a following call in the same time step only
	// updates the payload. While idling is enabled, a random gap may come
	// first; no gaps are taken while the receiver is being held off, so the
	// pipeline fills up behind the stall.
	task automatic send_point(input int x, input int y);
		if (idling && !hold_request && !rx_holding && $urandom_range(0, 3) == 0) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.point_x <= x[COORD_BITS-1:0];
		pixel.point_y <= y[COORD_BITS-1:0];
		do
			@(posedge clk);
		while (!pixel.ready);
	endtask

	// Drops valid and waits until every predicted tile has been transferred.
	// The first edge lets the checker's count catch up with the last point.
	task automatic settle();
		pixel.valid <= 1'b0;
		do
			@(posedge clk);
		while (tiles_owed != 0);
	endtask

	// One APB write: setup phase, then access phase until pready. Psel stays
	// high so that a following write goes straight into its setup phase.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
	endtask

	// Loads a full grid setting; only called while no point is in flight.
	task automatic set_grid(input int rad, input int ox, input int oy);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		psel <= 1'b0;
		penable <= 1'b0;
		cur_radius = rad;
		cur_ox = ox;
		cur_oy = oy;
		settings_count++;
	endtask

	// Random points: a share over the full field range so every bit toggles,
	// a share close to the origin where hexagons are small compared with the
	// spread, and a share on the rows where cube r lands exactly on a half.
	task automatic send_random_points(input int count);
		int rad;
		int span;
		int k;
		int x;
		int y;
		for (int n = 0; n < count; n++) begin
			rad = (cur_radius == 0) ? 1 : cur_radius;
			span = rad * 48;
			if (span > 32767)
				span = 32767;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					x = $urandom;
					y = $urandom;
				end
				4, 5, 6: begin
					x = cur_ox + int'($urandom_range(0, 2 * span)) - span;
					y = cur_oy + int'($urandom_range(0, 2 * span)) - span;
				end
				default: begin
					// A row boundary sits where dy is an odd multiple of 12*R.
					k = int'($urandom_range(0, 6)) - 3;
					x = cur_ox + int'($urandom_range(0, 2 * span)) - span;
					y = cur_oy + (2 * k + 1) * 12 * rad + int'($urandom_range(0, 2)) - 1;
				end
			endcase
			send_point(x, y);
		end
		settle();
	endtask

	// Tile receiver. Ready runs high for random stretches, with random
	// low bursts while idling is enabled. On request it holds ready low for a
	// long count of its own while the sender keeps offering points.
	initial begin
		tile.ready <= 1'b0;
		rx_holding = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rx_holding = 1'b1;
				tile.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				tile.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			tile.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Watchdog: any transfer on either channel or the APB port counts as
	// progress. A long run of cycles with none ends the test.
	always @(posedge clk) begin
		if (!arst_n || (pixel.valid && pixel.ready) || (tile.valid && tile.ready)
				|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d tiles outstanding",
					quiet_cycles, tiles_owed);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int rad;
		int ox;
		int oy;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixel.valid <= 1'b0;
		pixel.point_x <= '0;
		pixel.point_y <= '0;
		idling = 1'b1;
		hold_request = 1'b0;
		cur_radius = 32;
		cur_ox = 0;
		cur_oy = 0;
		settings_count = 1;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid, radius 32 and origin zero. The origin itself has all
		// three rounding errors equal at zero, so the tie rule picks s. The
		// rows at dy = +-24 px and +-72 px put cube r exactly on a half.
		send_point(0, 0);
		send_point(32767, 32767);
		send_point(-32768, -32768);
		send_point(32767, -32768);
		send_point(-32768, 32767);
		send_point(0, 384);
		send_point(0, -384);
		send_point(0, 1152);
		send_point(1, -1);
		settle();

		// Smallest radius with the origin at opposite corners of the field:
		// the widest differences and the largest cube coordinates.
		set_grid(1, -32768, 32767);
		send_point(32767, -32768);
		send_point(-32768, 32767);
		send_point(0, 0);
		send_point(-1, 0);
		settle();

		// A zero radius acts as radius one; dy = 12 is a half row there.
		set_grid(0, 0, 0);
		send_point(0, 12);
		send_point(0, -12);
		send_point(7, 5);
		send_point(32767, -1);
		settle();

		// Largest radius with the other extreme origin.
		set_grid(1023, 32767, -32768);
		send_point(-32768, 32767);
		send_point(32767, -32768);
		send_point(0, 0);
		send_point(-32768, -32768);
		settle();

		// Random phases, each under a fresh grid setting. The second phase
		// starts with a long receiver hold-off; the last runs with no idling.
		for (int ph = 0; ph < 5; ph++) begin
			ox = int'($urandom_range(0, 65535)) - 32768;
			oy = int'($urandom_range(0, 65535)) - 32768;
			case (ph)
				0: rad = $urandom_range(1, 64);
				1: rad = $urandom_range(2, 20);
				2: rad = 1023;
				3: rad = $urandom_range(0, 1023);
				default: rad = $urandom_range(1, 100);
			endcase
			if (ph == 4)
				idling = 1'b0;
			set_grid(rad, ox, oy);
			if (ph == 1)
				hold_request = 1'b1;
			send_random_points(POINTS_PER_PHASE);
		end

		// Everything has drained; give a stray late tile time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d points and %0d tiles over %0d grid settings,",
			points_seen, tiles_checked, settings_count);
		$display("including radius 0, 1 and 1023, both origin extremes and a full stall.");
		if (mismatches == 0 && tiles_owed == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
src/pxhex_pkg.sv
src/pxhex_if.sv
src/pxhex_cfg.sv
src/pxhex_front.sv
src/pxhex_div.sv
src/pxhex_round.sv
src/pixel_to_hex_offset_coords.sv
tb/hex_tile_checker.sv
tb/tb.sv
